@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the evaluator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is held
`define SPE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked property that also holds through reset
`define SPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// Types, codes and Q16.16 arithmetic helpers of the polynomial evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

    localparam int QW = 32;

    typedef logic signed [QW-1:0] t_q;

    // Q16.16 one
    localparam t_q Q_ONE = 32'sh0001_0000;

    // configuration register indexes
    localparam logic [2:0] CFG_DILATION    = 3'd0;
    localparam logic [2:0] CFG_TRANSLATION = 3'd1;
    localparam logic [2:0] CFG_LOWER       = 3'd2;
    localparam logic [2:0] CFG_UPPER       = 3'd3;
    localparam logic [2:0] CFG_BOUNDS_EN   = 3'd4;

    // configuration reset values
    localparam t_q RST_DILATION    = 32'sh0001_0000;
    localparam t_q RST_TRANSLATION = 32'sh0000_0000;
    localparam t_q RST_LOWER       = 32'sh0000_0000;
    localparam t_q RST_UPPER       = 32'sh0000_0000;

    // input mode codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // multiplier operand selection
    localparam logic [1:0] MUL_NX = 2'd0;   // dilation * x
    localparam logic [1:0] MUL_PT = 2'd1;   // power * t
    localparam logic [1:0] MUL_PC = 2'd2;   // power * coefficient

    typedef struct packed {
        logic       wr_coef;
        logic       ld_x;
        logic       chk;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       ld_t;
        logic       acc_en;
        logic       p_upd;
        logic       k_inc;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic oob;
        logic first;
        logic last;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic ovf;
        t_q   val;
    } t_sat;

    // Round a 64 bit Q32.32 product half up to Q16.16 and saturate
    function automatic t_sat rnd_sat(input logic signed [63:0] prod);
        logic signed [63:0] v;
        logic signed [47:0] q;
        t_sat r;
        v = prod + 64'sd32768;
        q = 48'(v >>> 16);
        if ((&q[47:31]) || !(|q[47:31])) begin
            r.ovf = 1'b0;
            r.val = q[31:0];
        end else begin
            r.ovf = 1'b1;
            r.val = q[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Saturating add (sub = 0) or subtract (sub = 1)
    function automatic t_sat sat_addsub(input t_q a, input t_q b, input logic sub);
        logic signed [32:0] s;
        t_sat r;
        s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (s[32] == s[31]) begin
            r.ovf = 1'b0;
            r.val = s[31:0];
        end else begin
            r.ovf = 1'b1;
            r.val = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/spe_ctrl.sv @@
// ----------------------------------------------------------------------------
// spe_ctrl
// Sequencer of the evaluator: input handshake and per-term command schedule.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spe_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire             i_mode,
    input  spe_pkg::t_status i_status,
    output spe_pkg::t_cmd   o_cmd
);
    import spe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_TSUB  = 3'd2;
    localparam logic [2:0] S_MPOW  = 3'd3;
    localparam logic [2:0] S_MTERM = 3'd4;
    localparam logic [2:0] S_FACC  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_NX;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_EVAL) begin
                        o_cmd.ld_x = 1'b1;
                        n_state    = S_CHECK;
                    end else begin
                        o_cmd.wr_coef = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.chk     = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NX;
                n_state       = i_status.oob ? S_OUT : S_TSUB;
            end
            S_TSUB: begin
                o_cmd.ld_t = 1'b1;
                n_state    = S_MPOW;
            end
            S_MPOW: begin
                // fold in the previous term, start the next power
                o_cmd.acc_en  = !i_status.first;
                o_cmd.mul_en  = !i_status.last;
                o_cmd.mul_sel = MUL_PT;
                n_state       = S_MTERM;
            end
            S_MTERM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PC;
                o_cmd.p_upd   = !i_status.last;
                o_cmd.k_inc   = !i_status.last;
                n_state       = i_status.last ? S_FACC : S_MPOW;
            end
            S_FACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the result
                if (!i_status.out_busy) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SPE_ASSERT(a_check_exit, i_clk, i_rst_n, (r_state == S_CHECK) |=> (r_state == S_OUT || r_state == S_TSUB), "bounds check must lead to output or setup")
    `SPE_ASSERT(a_term_loop, i_clk, i_rst_n, (r_state == S_MTERM && !i_status.last) |=> (r_state == S_MPOW), "non-final term must start the next power")
    `SPE_ASSERT(a_out_once, i_clk, i_rst_n, o_cmd.out_ld |=> (r_state == S_IDLE && !o_cmd.out_ld), "result must be loaded once per evaluation")

endmodule

`default_nettype wire

@@ design/spe_dp.sv @@
// ----------------------------------------------------------------------------
// spe_dp
// Datapath: configuration, coefficient store, shared multiplier, output slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spe_dp #(
    parameter int MAX_TERMS = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [2:0]       i_cfg_addr,
    input  wire  [31:0]      i_cfg_wdata,
    input  wire  [2:0]       i_cidx,
    input  wire  [31:0]      i_cval,
    input  wire  [31:0]      i_x,
    input  spe_pkg::t_cmd    i_cmd,
    output spe_pkg::t_status o_status,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [31:0]      o_y,
    output logic             o_oob,
    output logic             o_ovf
);
    import spe_pkg::*;

    localparam int IDXW = $clog2(MAX_TERMS);

    // configuration registers
    t_q   r_dil;
    t_q   r_trn;
    t_q   r_lo;
    t_q   r_hi;
    logic r_ben;

    // coefficient store and nonzero marks
    t_q                   r_coef [MAX_TERMS];
    logic [MAX_TERMS-1:0] r_nz;

    // evaluation state
    t_q                 r_x;
    t_q                 r_t;
    t_q                 r_p;
    t_q                 r_y;
    logic               r_ovf;
    logic               r_oob;
    logic [IDXW-1:0]    r_k;
    logic signed [63:0] r_prod;

    // output slot
    logic        r_ovalid;
    logic [31:0] r_oy;
    logic        r_ooob;
    logic        r_oovf;

    logic [31:0]          w_cidx_ext;
    logic                 w_cwr_ok;
    logic [IDXW-1:0]      w_widx;
    t_q                   w_coef_k;
    t_q                   w_ma;
    t_q                   w_mb;
    t_sat                 w_rnd;
    t_sat                 w_tsub;
    t_sat                 w_acc;
    logic [MAX_TERMS-1:0] w_above;
    logic                 w_oob;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dil <= RST_DILATION;
            r_trn <= RST_TRANSLATION;
            r_lo  <= RST_LOWER;
            r_hi  <= RST_UPPER;
            r_ben <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DILATION:    r_dil <= i_cfg_wdata;
                CFG_TRANSLATION: r_trn <= i_cfg_wdata;
                CFG_LOWER:       r_lo  <= i_cfg_wdata;
                CFG_UPPER:       r_hi  <= i_cfg_wdata;
                CFG_BOUNDS_EN:   r_ben <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Drop writes to indexes beyond the store
    assign w_cidx_ext = 32'(i_cidx);
    assign w_cwr_ok   = (w_cidx_ext < 32'(MAX_TERMS));
    assign w_widx     = w_cidx_ext[IDXW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef && w_cwr_ok) begin
            r_coef[w_widx] <= i_cval;
        end
    end

    // An entry whose mark is clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= '0;
        end else if (i_cmd.wr_coef && w_cwr_ok) begin
            r_nz[w_widx] <= |i_cval;
        end
    end

    assign w_coef_k = r_nz[r_k] ? r_coef[r_k] : '0;

    // Current term is the last when no nonzero coefficient lies above it
    assign w_above = r_nz >> ({1'b0, r_k} + (IDXW+1)'(1));

    assign w_oob = r_ben && ((r_x < r_lo) || (r_x > r_hi));

    always_comb begin
        o_status.oob      = w_oob;
        o_status.first    = (r_k == '0);
        o_status.last     = ~|w_above;
        o_status.out_busy = r_ovalid && !i_ready;
    end

    // Shared multiplier, product registered
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_NX: begin
                w_ma = r_dil;
                w_mb = r_x;
            end
            MUL_PT: begin
                w_ma = r_p;
                w_mb = r_t;
            end
            MUL_PC: begin
                w_ma = r_p;
                w_mb = w_coef_k;
            end
            default: begin
                w_ma = r_p;
                w_mb = r_t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
    end

    assign w_rnd  = rnd_sat(r_prod);
    assign w_tsub = sat_addsub(w_rnd.val, r_trn, 1'b1);
    assign w_acc  = sat_addsub(r_y, w_rnd.val, 1'b0);

    // Evaluation registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_x) begin
            r_x <= i_x;
        end
        if (i_cmd.chk) begin
            r_oob <= w_oob;
            r_y   <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.ld_t) begin
            r_t   <= w_tsub.val;
            r_p   <= Q_ONE;
            r_k   <= '0;
            r_ovf <= r_ovf | w_rnd.ovf | w_tsub.ovf;
        end else if (i_cmd.acc_en) begin
            r_y   <= w_acc.val;
            r_ovf <= r_ovf | w_rnd.ovf | w_acc.ovf;
        end else if (i_cmd.p_upd) begin
            r_p   <= w_rnd.val;
            r_ovf <= r_ovf | w_rnd.ovf;
        end
        if (i_cmd.k_inc) begin
            r_k <= r_k + IDXW'(1);
        end
    end

    // Output slot: load a finished result, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_oy   <= r_y;
            r_ooob <= r_oob;
            r_oovf <= r_ovf;
        end
    end

    assign o_valid = r_ovalid;
    assign o_y     = r_oy;
    assign o_oob   = r_ooob;
    assign o_ovf   = r_oovf;

    `SPE_ASSERT(a_oob_zero, i_clk, i_rst_n, (r_ovalid && r_ooob) |-> (r_oy == '0 && !r_oovf), "out-of-bounds result must be zero without overflow")
    `SPE_ASSERT(a_pow_not_last, i_clk, i_rst_n, i_cmd.p_upd |-> !o_status.last, "power must not advance past the final term")
    `SPE_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !r_ovalid, "output slot must be empty after reset")

endmodule

`default_nettype wire

@@ design/scaled_polynomial_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// scaled_polynomial_evaluator_unit
// Evaluates y = sum c_k * (N*x - L)^k in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on the s_axis group; tuser carries the mode.
//   Mode 0 stores coef_value at coef_index and gives no result. Mode 1 evaluates at
//   x_value and gives one request on the m_axis group with y_value in tdata and the
//   out_of_bounds / overflow flags in tuser. The user must write registers through the
//   cfg port only while the unit is idle; the unit itself does not enforce it.
// Sequence:
//   After an evaluation request is accepted the unit checks the bounds while forming
//   N*x, subtracts the translation, forms the power and the term product of each
//   coefficient up to the highest nonzero index, folds in the final term and loads the
//   result; a point outside enabled bounds goes straight from the check to the output.
//   The next request is taken on the cycle after the result is loaded; no new request
//   is taken while an evaluation is in progress. One shared 32x32 multiplier forms
//   the power and then the term product of each coefficient in turn.
// Reset and stalls:
//   Reset restores the register defaults and clears all coefficients.
//   A result waiting in the output register does not block the next
//   request; the unit stalls only when a second result is finished
//   while the first has still not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_polynomial_evaluator_unit #(
    parameter int MAX_TERMS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_wdata,
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [71:0] i_s_axis_tdata,   // coef_index[2:0], coef_value[34:3], x_value[66:35]
    input  wire  [0:0]  i_s_axis_tuser,   // mode[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // y_value[31:0]
    output logic [1:0]  o_m_axis_tuser    // out_of_bounds[0], overflow[1]
);
    import spe_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_oob;
    logic    w_ovf;

    spe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_mode   (i_s_axis_tuser[0]),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    spe_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cidx      (i_s_axis_tdata[2:0]),
        .i_cval      (i_s_axis_tdata[34:3]),
        .i_x         (i_s_axis_tdata[66:35]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_y         (o_m_axis_tdata),
        .o_oob       (w_oob),
        .o_ovf       (w_ovf)
    );

    assign o_m_axis_tuser = {w_ovf, w_oob};

endmodule

`default_nettype wire
